### design/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared widths, payload types and register indexes of the best-hit selector.
// ----------------------------------------------------------------------------
`default_nettype none

package bhs_pkg;

    localparam int ID_BITS         = 23;
    localparam int TGT_BITS        = 24;
    localparam int ABUND_BITS      = 32;
    localparam int TARGET_BITS_DEF = 24;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER_BY_SIZE = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_BOTH_STRANDS  = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic                  valid_req;
        logic                  hit_rejected;
        logic                  hit_aligned;
        logic                  hit_accepted;
        logic [ID_BITS-1:0]    identity;
        logic [TGT_BITS-1:0]   target_index;
        logic [ABUND_BITS-1:0] abundance;
        logic                  strand;
        logic                  last_hit;
    } hit_t;

    typedef struct packed {
        logic                found;
        logic [TGT_BITS-1:0] best_target;
        logic [ID_BITS-1:0]  best_identity;
        logic                best_strand;
    } res_t;

    typedef struct packed {
        logic order_by_size;
        logic both_strands;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic last;
    } step_t;

endpackage

`default_nettype wire

### design/bhs_if.sv
// ----------------------------------------------------------------------------
// bhs_if
// Valid/ready channels of the best-hit selector: hits, results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhs_hit_if;
    logic                            valid;
    logic                            ready;
    logic                            valid_req;
    logic                            hit_rejected;
    logic                            hit_aligned;
    logic                            hit_accepted;
    logic [bhs_pkg::ID_BITS-1:0]     identity;
    logic [bhs_pkg::TGT_BITS-1:0]    target_index;
    logic [bhs_pkg::ABUND_BITS-1:0]  abundance;
    logic                            strand;
    logic                            last_hit;

    modport source (
        output valid, valid_req, hit_rejected, hit_aligned, hit_accepted,
               identity, target_index, abundance, strand, last_hit,
        input  ready
    );
    modport sink (
        input  valid, valid_req, hit_rejected, hit_aligned, hit_accepted,
               identity, target_index, abundance, strand, last_hit,
        output ready
    );
endinterface

interface bhs_res_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [bhs_pkg::TGT_BITS-1:0] best_target;
    logic [bhs_pkg::ID_BITS-1:0]  best_identity;
    logic                         best_strand;

    modport source (
        output valid, found, best_target, best_identity, best_strand,
        input  ready
    );
    modport sink (
        input  valid, found, best_target, best_identity, best_strand,
        output ready
    );
endinterface

interface bhs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bhs_pkg::CFG_IDX_BITS-1:0] index;
    logic                             data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

### design/best_hit_selector_top.sv
// ----------------------------------------------------------------------------
// best_hit_selector_top
// Keeps the best hit of a streamed hit list and reports it at list end.
// ----------------------------------------------------------------------------
// Hits enter on the hit channel at one per cycle; each passes an input
// register, is compared against the kept best combinationally, and on the
// item marked last_hit one result beat is loaded into the output register
// as that item leaves the input register. The single compare against the
// kept registers sets the rate of one hit per cycle; a list end stalls
// only while the previous result is still held.
// Configuration writes take effect on the next compare.
// ----------------------------------------------------------------------------
`default_nettype none

module best_hit_selector_top #(
    parameter int TARGET_BITS = bhs_pkg::TARGET_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bhs_hit_if.sink    hit,
    bhs_res_if.source  res,
    bhs_cfg_if.sink    cfg
);

    bhs_pkg::cfg_t  cfg_reg;
    bhs_pkg::cfg_t  cfg_next;
    logic           s1_vld_reg;
    logic           s1_vld_next;
    bhs_pkg::hit_t  s1_item_reg;
    logic           out_vld_reg;
    logic           out_vld_next;
    bhs_pkg::res_t  out_res_reg;
    bhs_pkg::hit_t  hit_item;
    bhs_pkg::res_t  keep_res;
    bhs_pkg::step_t step;
    logic           hit_fire;
    logic           s1_go;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                bhs_pkg::CFG_ORDER_BY_SIZE: cfg_next.order_by_size = cfg.data;
                bhs_pkg::CFG_BOTH_STRANDS:  cfg_next.both_strands  = cfg.data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        hit_item.valid_req    = hit.valid_req;
        hit_item.hit_rejected = hit.hit_rejected;
        hit_item.hit_aligned  = hit.hit_aligned;
        hit_item.hit_accepted = hit.hit_accepted;
        hit_item.identity     = hit.identity;
        hit_item.target_index = hit.target_index;
        hit_item.abundance    = hit.abundance;
        hit_item.strand       = hit.strand;
        hit_item.last_hit     = hit.last_hit;
    end

    // hold a list end while the previous result waits
    assign s1_go     = s1_vld_reg && (!s1_item_reg.last_hit || !out_vld_reg || res.ready);
    assign hit.ready = !s1_vld_reg || s1_go;
    assign hit_fire  = hit.valid && hit.ready;

    assign step.take = s1_go;
    assign step.last = s1_item_reg.last_hit;

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (hit_fire)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (s1_go && s1_item_reg.last_hit)
        begin
            out_vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    bhs_keep #(
        .TARGET_BITS (TARGET_BITS)
    ) u_keep (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .step  (step),
        .item  (s1_item_reg),
        .res   (keep_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg     <= '0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_fire)
        begin
            s1_item_reg <= hit_item;
        end
        if (s1_go && s1_item_reg.last_hit)
        begin
            out_res_reg <= keep_res;
        end
    end

    assign res.valid         = out_vld_reg;
    assign res.found         = out_res_reg.found;
    assign res.best_target   = out_res_reg.best_target;
    assign res.best_identity = out_res_reg.best_identity;
    assign res.best_strand   = out_res_reg.best_strand;

`ifndef SYNTHESIS
    a_end_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_item_reg.last_hit |=> out_vld_reg)
        else $error("list end produced no result");

    a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        hit_fire |=> s1_vld_reg)
        else $error("accepted hit lost");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && !s1_go |-> s1_item_reg.last_hit && out_vld_reg && !res.ready)
        else $error("input stage stalled without cause");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_vld_reg |-> hit.ready)
        else $error("empty input stage not ready");
`endif

endmodule

`default_nettype wire

### design/bhs_keep.sv
// ----------------------------------------------------------------------------
// bhs_keep
// Kept best hit, one lexicographic compare per hit, end-of-list result.
// ----------------------------------------------------------------------------
`default_nettype none

module bhs_keep #(
    parameter int TARGET_BITS = bhs_pkg::TARGET_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bhs_pkg::cfg_t cfg,
    input  wire bhs_pkg::step_t step,
    input  wire bhs_pkg::hit_t item,
    output bhs_pkg::res_t      res
);

    localparam int KEEP_BITS =
        (TARGET_BITS < bhs_pkg::TGT_BITS) ? TARGET_BITS : bhs_pkg::TGT_BITS;

    logic                             have_best_reg;
    logic                             have_best_next;
    logic                             kept_rejected_reg;
    logic                             kept_aligned_reg;
    logic                             kept_accepted_reg;
    logic [bhs_pkg::ID_BITS-1:0]      kept_identity_reg;
    logic [KEEP_BITS-1:0]             kept_target_reg;
    logic [bhs_pkg::ABUND_BITS-1:0]   kept_abundance_reg;
    logic                             kept_strand_reg;

    logic [KEEP_BITS-1:0]             tgt;
    logic                             cand;
    logic                             beats;
    logic                             upd;
    logic                             have_now;
    logic                             acc_now;
    logic [bhs_pkg::ID_BITS-1:0]      id_now;
    logic [KEEP_BITS-1:0]             tgt_now;
    logic                             strand_now;

    assign tgt  = item.target_index[KEEP_BITS-1:0];
    assign cand = item.valid_req && (!item.strand || cfg.both_strands);

    always_comb
    begin
        if (item.hit_rejected != kept_rejected_reg)
        begin
            beats = !item.hit_rejected;
        end
        else if (cfg.order_by_size && item.hit_rejected)
        begin
            beats = 1'b0;
        end
        else if (item.hit_aligned != kept_aligned_reg)
        begin
            beats = item.hit_aligned;
        end
        else if (!item.hit_aligned)
        begin
            beats = 1'b0;
        end
        else if (cfg.order_by_size && (item.abundance != kept_abundance_reg))
        begin
            beats = item.abundance > kept_abundance_reg;
        end
        else if (item.identity != kept_identity_reg)
        begin
            beats = item.identity > kept_identity_reg;
        end
        else
        begin
            beats = tgt < kept_target_reg;
        end
    end

    assign upd        = step.take && cand && (!have_best_reg || beats);
    assign have_now   = have_best_reg || upd;
    assign acc_now    = upd ? item.hit_accepted : kept_accepted_reg;
    assign id_now     = upd ? item.identity     : kept_identity_reg;
    assign tgt_now    = upd ? tgt               : kept_target_reg;
    assign strand_now = upd ? item.strand       : kept_strand_reg;

    always_comb
    begin
        res = '0;
        if (have_now && acc_now)
        begin
            res.found         = 1'b1;
            res.best_target   = bhs_pkg::TGT_BITS'(tgt_now);
            res.best_identity = id_now;
            res.best_strand   = strand_now;
        end
    end

    always_comb
    begin
        have_best_next = have_best_reg;
        if (step.take)
        begin
            have_best_next = step.last ? 1'b0 : have_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_best_reg <= 1'b0;
        end
        else
        begin
            have_best_reg <= have_best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            kept_rejected_reg  <= item.hit_rejected;
            kept_aligned_reg   <= item.hit_aligned;
            kept_accepted_reg  <= item.hit_accepted;
            kept_identity_reg  <= item.identity;
            kept_target_reg    <= tgt;
            kept_abundance_reg <= item.abundance;
            kept_strand_reg    <= item.strand;
        end
    end

`ifndef SYNTHESIS
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step.take && step.last |=> !have_best_reg)
        else $error("kept hit survives end of list");

    a_cand_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        step.take && cand && !step.last |=> have_best_reg)
        else $error("eligible hit not kept");

    a_upd_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        upd |-> step.take && item.valid_req)
        else $error("kept hit replaced without a hit");
`endif

endmodule

`default_nettype wire

### verif/best_hit_selector_top_tb.sv
// ----------------------------------------------------------------------------
// best_hit_selector_top_tb
// Self-checking bench for the best-hit selector.
// ----------------------------------------------------------------------------
// Hit lists are streamed into the hit channel. A local copy of the ranking
// logic folds each accepted beat into its own kept hit and queues the result
// due at each list end. Every result beat is compared field by field with
// the oldest queued result. The bench covers directed lists for both
// orders, the strand filter, ties, empty lists, config changes in an open
// list, then random lists with and without random idle bursts on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module best_hit_selector_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 4;

    logic clk;
    logic rst_n;

    bhs_hit_if hit_ch ();
    bhs_res_if res_ch ();
    bhs_cfg_if cfg_ch ();

    best_hit_selector_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hit   (hit_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    bhs_pkg::cfg_t  cfg_model;
    bhs_pkg::hit_t  kept_hit;
    bit             kept_have;
    bhs_pkg::res_t  best_hits_due[$];
    int             mismatches;
    int             cycles;
    bit             gaps_on;
    bit             stalls_on;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Ranking model
    // ------------------------------------------------------------------
    function automatic bit outranks_kept(input bhs_pkg::hit_t h);
        if (h.hit_rejected != kept_hit.hit_rejected)
            return !h.hit_rejected;
        if (cfg_model.order_by_size && h.hit_rejected)
            return 1'b0;
        if (h.hit_aligned != kept_hit.hit_aligned)
            return h.hit_aligned;
        if (!h.hit_aligned)
            return 1'b0;
        if (cfg_model.order_by_size && h.abundance != kept_hit.abundance)
            return h.abundance > kept_hit.abundance;
        if (h.identity != kept_hit.identity)
            return h.identity > kept_hit.identity;
        return h.target_index < kept_hit.target_index;
    endfunction

    task automatic fold_hit(input bhs_pkg::hit_t h);
        bhs_pkg::res_t r;
        if (h.valid_req && (!h.strand || cfg_model.both_strands))
        begin
            if (!kept_have || outranks_kept(h))
            begin
                kept_have = 1'b1;
                kept_hit  = h;
            end
        end
        if (h.last_hit)
        begin
            r = '0;
            if (kept_have && kept_hit.hit_accepted)
            begin
                r.found         = 1'b1;
                r.best_target   = kept_hit.target_index;
                r.best_identity = kept_hit.identity;
                r.best_strand   = kept_hit.strand;
            end
            best_hits_due.push_back(r);
            kept_have = 1'b0;
            kept_hit  = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t",
                 what, want, got, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        bhs_pkg::res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (best_hits_due.size() == 0)
                note_mismatch("result with none due", 32'd0, 32'd1);
            else
            begin
                want = best_hits_due.pop_front();
                if (res_ch.found !== want.found)
                    note_mismatch("found", 32'(want.found), 32'(res_ch.found));
                if (res_ch.best_target !== want.best_target)
                    note_mismatch("best_target", 32'(want.best_target),
                                  32'(res_ch.best_target));
                if (res_ch.best_identity !== want.best_identity)
                    note_mismatch("best_identity", 32'(want.best_identity),
                                  32'(res_ch.best_identity));
                if (res_ch.best_strand !== want.best_strand)
                    note_mismatch("best_strand", 32'(want.best_strand),
                                  32'(res_ch.best_strand));
            end
        end
    end

    // stall the result side in random bursts
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic bhs_pkg::hit_t make_hit(input bit v, input bit rej, input bit ali,
                                      input bit acc,
                                      input logic [bhs_pkg::ID_BITS-1:0] id,
                                      input logic [bhs_pkg::TGT_BITS-1:0] tgt,
                                      input logic [bhs_pkg::ABUND_BITS-1:0] ab,
                                      input bit st, input bit last);
        bhs_pkg::hit_t h;
        h.valid_req    = v;
        h.hit_rejected = rej;
        h.hit_aligned  = ali;
        h.hit_accepted = acc;
        h.identity     = id;
        h.target_index = tgt;
        h.abundance    = ab;
        h.strand       = st;
        h.last_hit     = last;
        return h;
    endfunction

    function automatic logic [bhs_pkg::ID_BITS-1:0] pct(input int p);
        return bhs_pkg::ID_BITS'(p * 65536);
    endfunction

    // called at a falling edge; returns at a falling edge with valid held
    task automatic send_hit(input bhs_pkg::hit_t h);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            hit_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        hit_ch.valid        <= 1'b1;
        hit_ch.valid_req    <= h.valid_req;
        hit_ch.hit_rejected <= h.hit_rejected;
        hit_ch.hit_aligned  <= h.hit_aligned;
        hit_ch.hit_accepted <= h.hit_accepted;
        hit_ch.identity     <= h.identity;
        hit_ch.target_index <= h.target_index;
        hit_ch.abundance    <= h.abundance;
        hit_ch.strand       <= h.strand;
        hit_ch.last_hit     <= h.last_hit;
        @(posedge clk);
        while (!hit_ch.ready)
            @(posedge clk);
        fold_hit(h);
        @(negedge clk);
    endtask

    // drop the hit channel and wait until the block has drained
    task automatic settle();
        hit_ch.valid <= 1'b0;
        while (best_hits_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bhs_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == bhs_pkg::CFG_ORDER_BY_SIZE)
            cfg_model.order_by_size = value;
        else if (idx == bhs_pkg::CFG_BOTH_STRANDS)
            cfg_model.both_strands = value;
        @(negedge clk);
    endtask

    task automatic set_config(input bit by_size, input bit both);
        settle();
        write_reg(bhs_pkg::CFG_ORDER_BY_SIZE, by_size);
        write_reg(bhs_pkg::CFG_BOTH_STRANDS, both);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic bhs_pkg::hit_t random_hit(input bit last);
        bhs_pkg::hit_t h;
        h.valid_req    = ($urandom_range(0, 15) != 0);
        h.hit_rejected = ($urandom_range(0, 3) == 0);
        h.hit_aligned  = ($urandom_range(0, 3) != 0);
        h.hit_accepted = ($urandom_range(0, 2) != 0);
        case ($urandom_range(0, 2))
            0: h.identity = pct(int'($urandom_range(95, 100)));
            1: h.identity = bhs_pkg::ID_BITS'($urandom_range(0, 6553600));
            default: h.identity = bhs_pkg::ID_BITS'($urandom());
        endcase
        if ($urandom_range(0, 1) == 0)
            h.target_index = bhs_pkg::TGT_BITS'($urandom_range(0, 7));
        else
            h.target_index = bhs_pkg::TGT_BITS'($urandom());
        if ($urandom_range(0, 1) == 0)
            h.abundance = bhs_pkg::ABUND_BITS'($urandom_range(1, 4));
        else
            h.abundance = $urandom();
        h.strand   = 1'($urandom_range(0, 1));
        h.last_hit = last;
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_identity_order();
        // reset config: order by identity, minus strand ignored
        send_hit(make_hit(1, 0, 1, 1, pct(90), 5, 10, 0, 0));
        send_hit(make_hit(1, 0, 1, 1, pct(90), 3, 1, 0, 0));
        send_hit(make_hit(1, 0, 1, 0, pct(90), 3, 99, 0, 0));
        send_hit(make_hit(1, 0, 1, 1, 23'h7FFFFF, 0, 0, 1, 0));
        send_hit(make_hit(0, 0, 1, 1, 23'h7FFFFF, 7, 0, 0, 0));
        send_hit(make_hit(1, 1, 1, 1, 23'h7FFFFF, 9, 0, 0, 1));
        send_hit(make_hit(1, 0, 0, 1, 0, 24'hFFFFFF, 32'hFFFFFFFF, 0, 0));
        send_hit(make_hit(1, 0, 0, 1, 23'h7FFFFF, 1, 0, 0, 0));
        send_hit(make_hit(1, 0, 1, 0, 0, 24'hFFFFFF, 0, 0, 1));
        send_hit(make_hit(0, 0, 0, 0, 0, 0, 0, 0, 1));
        send_hit(make_hit(1, 1, 0, 1, pct(100), 24'h800000, 32'h80000000, 0, 1));
    endtask

    task automatic test_size_order();
        set_config(1'b1, 1'b1);
        send_hit(make_hit(1, 1, 1, 1, pct(99), 4, 500, 0, 0));
        send_hit(make_hit(1, 1, 1, 1, pct(100), 2, 900, 1, 0));
        send_hit(make_hit(1, 0, 1, 1, pct(50), 8, 100, 1, 0));
        send_hit(make_hit(1, 0, 1, 1, pct(40), 9, 200, 0, 0));
        send_hit(make_hit(1, 0, 1, 1, pct(45), 9, 200, 0, 0));
        send_hit(make_hit(1, 0, 1, 1, pct(45), 6, 200, 1, 1));
    endtask

    task automatic test_config_mid_list();
        set_config(1'b0, 1'b0);
        send_hit(make_hit(1, 0, 1, 1, pct(60), 1, 5, 0, 0));
        set_config(1'b1, 1'b0);
        send_hit(make_hit(1, 0, 1, 1, pct(50), 2, 6, 0, 0));
        set_config(1'b0, 1'b1);
        send_hit(make_hit(1, 0, 1, 1, pct(55), 3, 0, 1, 1));
    endtask

    task automatic test_random_lists(input int n_hits);
        int            sent;
        int            len;
        bhs_pkg::hit_t h;
        sent = 0;
        while (sent < n_hits)
        begin
            if ($urandom_range(0, 11) == 0)
                set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0)
            begin
                h = random_hit(1'b1);
                h.valid_req = 1'b0;
                send_hit(h);
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    h = random_hit(i == len - 1);
                    send_hit(h);
                    if (h.valid_req)
                        sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        hit_ch.valid        = 1'b0;
        hit_ch.valid_req    = 1'b0;
        hit_ch.hit_rejected = 1'b0;
        hit_ch.hit_aligned  = 1'b0;
        hit_ch.hit_accepted = 1'b0;
        hit_ch.identity     = '0;
        hit_ch.target_index = '0;
        hit_ch.abundance    = '0;
        hit_ch.strand       = 1'b0;
        hit_ch.last_hit     = 1'b0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = 1'b0;
        cfg_model           = '0;
        kept_hit            = '0;
        kept_have           = 1'b0;
        mismatches          = 0;
        cycles              = 0;
        gaps_on             = 1'b1;
        stalls_on           = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_identity_order();
        test_size_order();
        test_config_mid_list();
        test_random_lists(700);
        settle();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        test_random_lists(100);

        hit_ch.valid <= 1'b0;
        while (best_hits_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
